[design/nsc_pkg.sv]
// Shared types, character codes and lookup functions of the NMEA sentence checker.
package nsc_pkg;

  // Character codes
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_F   = 8'h66;
  localparam logic [7:0] CHAR_FIX_OK = 8'h41;  // 'A' in the RMC status term

  // Term bookkeeping
  localparam int HEAD_DEPTH = 5;
  localparam logic [2:0] LEN_SAT   = 3'd6;
  localparam logic [4:0] INDEX_SAT = 5'd31;
  localparam logic [4:0] RMC_STATUS_TERM = 5'd2;
  localparam logic [4:0] GGA_QUALITY_TERM = 5'd6;

  // Sentence kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_RMC   = 3'd1;
  localparam logic [2:0] KIND_GGA   = 3'd2;
  localparam logic [2:0] KIND_GSA   = 3'd3;
  localparam logic [2:0] KIND_GSV   = 3'd4;

  // Constellation codes
  localparam logic [2:0] SYS_UNKNOWN = 3'd0;
  localparam logic [2:0] SYS_GPS     = 3'd1;
  localparam logic [2:0] SYS_GLONASS = 3'd2;
  localparam logic [2:0] SYS_GALILEO = 3'd3;
  localparam logic [2:0] SYS_BEIDOU  = 3'd4;
  localparam logic [2:0] SYS_QZSS    = 3'd5;
  localparam logic [2:0] SYS_NAVIC   = 3'd6;

  typedef logic [7:0] char_t;
  typedef char_t [HEAD_DEPTH-1:0] head_t;

  // Result of closing one term
  typedef struct packed {
    logic       pass;
    logic       fail;
    logic [2:0] kind;
    logic [2:0] talker;
    logic       fix;
  } term_result_t;

  // Checksum digit value, modulo 256 for non-hex characters
  function automatic char_t hex_value(input char_t a);
    char_t v;
    if (a >= CHAR_UP_A && a <= CHAR_UP_F) begin
      v = a - CHAR_UP_A + 8'd10;
    end else if (a >= CHAR_LO_A && a <= CHAR_LO_F) begin
      v = a - CHAR_LO_A + 8'd10;
    end else begin
      v = a - CHAR_ZERO;
    end
    return v;
  endfunction

  // Talker letter lookup: bit 3 flags a known letter, bits 2:0 the system code
  function automatic logic [3:0] talker_lookup(input char_t a);
    logic [3:0] r;
    case (a)
      8'h50:   r = {1'b1, SYS_GPS};      // P
      8'h4E:   r = {1'b1, SYS_UNKNOWN};  // N
      8'h41:   r = {1'b1, SYS_GALILEO};  // A
      8'h42:   r = {1'b1, SYS_BEIDOU};   // B
      8'h4C:   r = {1'b1, SYS_GLONASS};  // L
      8'h51:   r = {1'b1, SYS_QZSS};     // Q
      8'h49:   r = {1'b1, SYS_NAVIC};    // I
      default: r = {1'b0, SYS_UNKNOWN};
    endcase
    return r;
  endfunction

  // Three-letter sentence type lookup
  function automatic logic [2:0] kind_lookup(input char_t a, input char_t b, input char_t c);
    logic [2:0] k;
    k = KIND_OTHER;
    if (a == 8'h52 && b == 8'h4D && c == 8'h43) k = KIND_RMC;       // RMC
    else if (a == 8'h47 && b == 8'h47 && c == 8'h41) k = KIND_GGA;  // GGA
    else if (a == 8'h47 && b == 8'h53 && c == 8'h41) k = KIND_GSA;  // GSA
    else if (a == 8'h47 && b == 8'h53 && c == 8'h56) k = KIND_GSV;  // GSV
    return k;
  endfunction

endpackage

[design/nsc_term_eval.sv]
// Evaluates the term that a delimiter closes: checksum verdict, sentence type, fix flag.
module nsc_term_eval (
  input  nsc_pkg::head_t        head,
  input  logic [2:0]            term_length,
  input  logic [4:0]            term_index,
  input  logic                  in_checksum,
  input  logic                  wide_crc,
  input  logic [7:0]            parity,
  input  logic [2:0]            kind,
  input  logic [2:0]            talker,
  input  logic                  fix,
  output nsc_pkg::term_result_t result
);

  logic [7:0] sum;
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [3:0] talk;
  logic [2:0] kind_hit;

  // Checksum byte from the first two characters of the term
  assign hi_val = nsc_pkg::hex_value(head[0]);
  assign lo_val = nsc_pkg::hex_value(head[1]);
  assign sum    = {hi_val[3:0], 4'b0000} + lo_val;

  // Sentence type from the address term
  assign talk     = nsc_pkg::talker_lookup(head[1]);
  assign kind_hit = nsc_pkg::kind_lookup(head[2], head[3], head[4]);

  always_comb begin
    result        = '0;
    result.kind   = kind;
    result.talker = talker;
    result.fix    = fix;
    if (in_checksum) begin
      // Close the checksum term; wide CRC sentences give no verdict
      if (!wide_crc) begin
        if (term_length < 3'd2) begin
          result.fail = 1'b1;
        end else if (sum == parity) begin
          result.pass = 1'b1;
        end else begin
          result.fail = 1'b1;
        end
      end
    end else if (term_index == 5'd0) begin
      // Classify the address term
      result.kind   = nsc_pkg::KIND_OTHER;
      result.talker = nsc_pkg::SYS_UNKNOWN;
      if (term_length == 3'(nsc_pkg::HEAD_DEPTH) && head[0] == 8'h47 && talk[3] &&
          kind_hit != nsc_pkg::KIND_OTHER) begin
        result.kind   = kind_hit;
        result.talker = talk[2:0];
      end
    end else if (kind != nsc_pkg::KIND_OTHER && term_length != 3'd0 && head[0] != 8'h00) begin
      // Pick up the fix flag from the status or quality term
      if (kind == nsc_pkg::KIND_RMC && term_index == nsc_pkg::RMC_STATUS_TERM) begin
        result.fix = (head[0] == nsc_pkg::CHAR_FIX_OK);
      end else if (kind == nsc_pkg::KIND_GGA && term_index == nsc_pkg::GGA_QUALITY_TERM) begin
        result.fix = (head[0] > nsc_pkg::CHAR_ZERO);
      end
    end
  end

endmodule

[design/nmea_sentence_checker.sv]
// NMEA 0183 sentence checker: per-character parser, checksum test and sentence counters.
//
// Use: feed the received NMEA stream one character per beat on in_char with
// in_valid/in_ready. Every accepted character yields exactly one result beat on
// the out_ channel. out_sentence_ok or out_checksum_bad pulses on the beat of the
// character that closes a checksum term; the other fields show the sentence kind,
// constellation, fix flag and the three wrapping 32-bit counters after that
// character. Sentences opened by '#' carry a wide CRC and give no verdict.
// The result of a character is on the outputs in the cycle after it is
// accepted. Throughput is one character per cycle while the receiver keeps up,
// set by the parser state registers that every character updates.
// When the receiver stalls, the result beat holds and in_ready drops until it is
// taken; in_ready stays high while a result is taken in the same cycle.
// Synchronous active-low reset clears the parser state, the counters and the
// result valid; characters before any '$' count as a sentence in progress.
module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sentence_ok,
  output logic        out_checksum_bad,
  output logic [2:0]  out_sentence_kind,
  output logic        out_has_fix,
  output logic [2:0]  out_system_code,
  output logic [31:0] out_passed_total,
  output logic [31:0] out_failed_total,
  output logic [31:0] out_fix_total
);

  logic                  in_fire;
  logic                  is_delim;
  logic                  is_start;
  logic [7:0]            parity_mid;
  nsc_pkg::term_result_t term_res;

  logic                  out_valid_r;
  logic                  sentence_ok_r,  sentence_ok_nxt;
  logic                  checksum_bad_r, checksum_bad_nxt;
  logic [7:0]            parity_r,       parity_nxt;
  logic                  in_cks_r,       in_cks_nxt;
  logic                  wide_crc_r,     wide_crc_nxt;
  logic [4:0]            term_index_r,   term_index_nxt;
  logic [2:0]            term_length_r,  term_length_nxt;
  nsc_pkg::head_t        head_r,         head_nxt;
  logic [2:0]            kind_r,         kind_nxt;
  logic [2:0]            talker_r,       talker_nxt;
  logic                  fix_r,          fix_nxt;
  logic [31:0]           pass_cnt_r,     pass_cnt_nxt;
  logic [31:0]           fail_cnt_r,     fail_cnt_nxt;
  logic [31:0]           fix_cnt_r,      fix_cnt_nxt;

  // Take a new beat whenever the result slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_delim = in_char inside {nsc_pkg::CHAR_COMMA, nsc_pkg::CHAR_CR,
                                    nsc_pkg::CHAR_LF, nsc_pkg::CHAR_STAR};
  assign is_start = in_char inside {nsc_pkg::CHAR_DOLLAR, nsc_pkg::CHAR_HASH};

  // Commas enter the parity before the term closes
  assign parity_mid = (in_char == nsc_pkg::CHAR_COMMA) ? (parity_r ^ in_char) : parity_r;

  nsc_term_eval u_term_eval (
    .head        (head_r),
    .term_length (term_length_r),
    .term_index  (term_index_r),
    .in_checksum (in_cks_r),
    .wide_crc    (wide_crc_r),
    .parity      (parity_mid),
    .kind        (kind_r),
    .talker      (talker_r),
    .fix         (fix_r),
    .result      (term_res)
  );

  // Next parser state for the current character
  always_comb begin
    sentence_ok_nxt  = 1'b0;
    checksum_bad_nxt = 1'b0;
    parity_nxt       = parity_r;
    in_cks_nxt       = in_cks_r;
    wide_crc_nxt     = wide_crc_r;
    term_index_nxt   = term_index_r;
    term_length_nxt  = term_length_r;
    head_nxt         = head_r;
    kind_nxt         = kind_r;
    talker_nxt       = talker_r;
    fix_nxt          = fix_r;
    pass_cnt_nxt     = pass_cnt_r;
    fail_cnt_nxt     = fail_cnt_r;
    fix_cnt_nxt      = fix_cnt_r;
    if (is_delim) begin
      // Close the term
      parity_nxt       = parity_mid;
      sentence_ok_nxt  = term_res.pass;
      checksum_bad_nxt = term_res.fail;
      kind_nxt         = term_res.kind;
      talker_nxt       = term_res.talker;
      fix_nxt          = term_res.fix;
      if (term_res.pass) begin
        pass_cnt_nxt = pass_cnt_r + 32'd1;
        if (fix_r) begin
          fix_cnt_nxt = fix_cnt_r + 32'd1;
        end
      end
      if (term_res.fail) begin
        fail_cnt_nxt = fail_cnt_r + 32'd1;
      end
      if (term_index_r < nsc_pkg::INDEX_SAT) begin
        term_index_nxt = term_index_r + 5'd1;
      end
      term_length_nxt = 3'd0;
      in_cks_nxt      = (in_char == nsc_pkg::CHAR_STAR);
    end else if (is_start) begin
      // Open a new sentence, keep the counters
      wide_crc_nxt    = (in_char == nsc_pkg::CHAR_HASH);
      term_index_nxt  = 5'd0;
      term_length_nxt = 3'd0;
      parity_nxt      = 8'h00;
      kind_nxt        = nsc_pkg::KIND_OTHER;
      talker_nxt      = nsc_pkg::SYS_UNKNOWN;
      in_cks_nxt      = 1'b0;
      fix_nxt         = 1'b0;
    end else begin
      // Store the head of the term and fold the body into the parity
      if (term_length_r < 3'(nsc_pkg::HEAD_DEPTH)) begin
        head_nxt[term_length_r] = in_char;
      end
      if (term_length_r < nsc_pkg::LEN_SAT) begin
        term_length_nxt = term_length_r + 3'd1;
      end
      if (!in_cks_r) begin
        parity_nxt = parity_r ^ in_char;
      end
    end
  end

  // Hold state and the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      sentence_ok_r  <= 1'b0;
      checksum_bad_r <= 1'b0;
      parity_r       <= 8'h00;
      in_cks_r       <= 1'b0;
      wide_crc_r     <= 1'b0;
      term_index_r   <= 5'd0;
      term_length_r  <= 3'd0;
      head_r         <= '0;
      kind_r         <= nsc_pkg::KIND_OTHER;
      talker_r       <= nsc_pkg::SYS_UNKNOWN;
      fix_r          <= 1'b0;
      pass_cnt_r     <= 32'd0;
      fail_cnt_r     <= 32'd0;
      fix_cnt_r      <= 32'd0;
    end else begin
      if (in_fire) begin
        out_valid_r    <= 1'b1;
        sentence_ok_r  <= sentence_ok_nxt;
        checksum_bad_r <= checksum_bad_nxt;
        parity_r       <= parity_nxt;
        in_cks_r       <= in_cks_nxt;
        wide_crc_r     <= wide_crc_nxt;
        term_index_r   <= term_index_nxt;
        term_length_r  <= term_length_nxt;
        head_r         <= head_nxt;
        kind_r         <= kind_nxt;
        talker_r       <= talker_nxt;
        fix_r          <= fix_nxt;
        pass_cnt_r     <= pass_cnt_nxt;
        fail_cnt_r     <= fail_cnt_nxt;
        fix_cnt_r      <= fix_cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sentence_ok   = sentence_ok_r;
  assign out_checksum_bad  = checksum_bad_r;
  assign out_sentence_kind = kind_r;
  assign out_has_fix       = fix_r;
  assign out_system_code   = talker_r;
  assign out_passed_total  = pass_cnt_r;
  assign out_failed_total  = fail_cnt_r;
  assign out_fix_total     = fix_cnt_r;

  // A verdict is either pass or fail, never both
  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    !(sentence_ok_r && checksum_bad_r))
    else $error("pass and fail pulses together");

  // A pass beat advances the pass counter by one
  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && term_res.pass && is_delim |=> pass_cnt_r == $past(pass_cnt_r) + 32'd1)
    else $error("pass counter did not advance");

  // Counters only move on an accepted beat
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(pass_cnt_r) && $stable(fail_cnt_r) && $stable(fix_cnt_r))
    else $error("counter moved without an accepted beat");

  // Wide CRC sentences never give a verdict
  a_wide_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && wide_crc_r |=> !sentence_ok_r && !checksum_bad_r)
    else $error("verdict inside a wide CRC sentence");

  // The fix counter never runs ahead of a pass
  a_fix_with_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !(is_delim && term_res.pass) |=> $stable(fix_cnt_r))
    else $error("fix counter moved without a pass");

endmodule

[tb/sv/tb_nmea_sentence_checker.sv]
// Self-checking testbench of the NMEA sentence checker with its own parser model.
`timescale 1ns / 1ps

module tb_nmea_sentence_checker;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  // One result beat as the block should present it
  typedef struct packed {
    logic        ok;
    logic        bad;
    logic [2:0]  kind;
    logic        fix;
    logic [2:0]  sys;
    logic [31:0] passed;
    logic [31:0] failed;
    logic [31:0] fixes;
  } char_status_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char;
  logic        out_valid;
  logic        out_ready;
  logic        out_sentence_ok;
  logic        out_checksum_bad;
  logic [2:0]  out_sentence_kind;
  logic        out_has_fix;
  logic [2:0]  out_system_code;
  logic [31:0] out_passed_total;
  logic [31:0] out_failed_total;
  logic [31:0] out_fix_total;

  // Parser model state
  logic [7:0]      sum_acc      = 8'h00;
  logic            in_sum_term  = 1'b0;
  logic            crc_sentence = 1'b0;
  logic [4:0]      term_no      = 5'd0;
  logic [2:0]      term_chars   = 3'd0;
  nsc_pkg::head_t  head_chars   = '0;
  logic [2:0]      cur_kind     = nsc_pkg::KIND_OTHER;
  logic [2:0]      cur_sys      = nsc_pkg::SYS_UNKNOWN;
  logic            cur_fix      = 1'b0;
  logic [31:0]     n_passed     = '0;
  logic [31:0]     n_failed     = '0;
  logic [31:0]     n_fixed      = '0;

  char_status_t status_q[$];
  logic [7:0]   frame_q[$];
  logic [7:0]   frame_sum;
  logic         idling        = 1'b0;
  int           rx_hold_cycles = 0;
  int           mismatch_count = 0;
  int           results_seen   = 0;

  nmea_sentence_checker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sentence_ok   (out_sentence_ok),
    .out_checksum_bad  (out_checksum_bad),
    .out_sentence_kind (out_sentence_kind),
    .out_has_fix       (out_has_fix),
    .out_system_code   (out_system_code),
    .out_passed_total  (out_passed_total),
    .out_failed_total  (out_failed_total),
    .out_fix_total     (out_fix_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Value of one checksum digit; non-hex characters wrap around '0'
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    if (c >= "a" && c <= "f") return c - "a" + 8'd10;
    return c - nsc_pkg::CHAR_ZERO;
  endfunction

  // Constellation of a talker letter, -1 when the letter is not known
  function automatic int talker_of(input logic [7:0] c);
    case (c)
      "P":     return nsc_pkg::SYS_GPS;
      "N":     return nsc_pkg::SYS_UNKNOWN;
      "A":     return nsc_pkg::SYS_GALILEO;
      "B":     return nsc_pkg::SYS_BEIDOU;
      "L":     return nsc_pkg::SYS_GLONASS;
      "Q":     return nsc_pkg::SYS_QZSS;
      "I":     return nsc_pkg::SYS_NAVIC;
      default: return -1;
    endcase
  endfunction

  // Advance the parser model by one character and queue the expected beat
  task automatic parse_char(input logic [7:0] c);
    char_status_t r;
    logic [7:0]   sum;
    int           sys_hit;
    r = '0;
    if (c == nsc_pkg::CHAR_COMMA || c == nsc_pkg::CHAR_CR || c == nsc_pkg::CHAR_LF ||
        c == nsc_pkg::CHAR_STAR) begin
      if (c == nsc_pkg::CHAR_COMMA) sum_acc ^= c;
      if (in_sum_term) begin
        // close the checksum term; wide CRC sentences give no verdict
        if (!crc_sentence) begin
          sum = (digit_of(head_chars[0]) << 4) + digit_of(head_chars[1]);
          if (term_chars >= 3'd2 && sum == sum_acc) begin
            r.ok = 1'b1;
            n_passed++;
            if (cur_fix) n_fixed++;
          end else begin
            r.bad = 1'b1;
            n_failed++;
          end
        end
      end else if (term_no == 5'd0) begin
        // sort the address term
        cur_kind = nsc_pkg::KIND_OTHER;
        cur_sys  = nsc_pkg::SYS_UNKNOWN;
        sys_hit  = talker_of(head_chars[1]);
        if (term_chars == 3'd5 && head_chars[0] == "G" && sys_hit >= 0) begin
          case ({head_chars[2], head_chars[3], head_chars[4]})
            "RMC":   cur_kind = nsc_pkg::KIND_RMC;
            "GGA":   cur_kind = nsc_pkg::KIND_GGA;
            "GSA":   cur_kind = nsc_pkg::KIND_GSA;
            "GSV":   cur_kind = nsc_pkg::KIND_GSV;
            default: cur_kind = nsc_pkg::KIND_OTHER;
          endcase
          if (cur_kind != nsc_pkg::KIND_OTHER) cur_sys = sys_hit[2:0];
        end
      end else if (cur_kind != nsc_pkg::KIND_OTHER && term_chars != 3'd0 &&
                   head_chars[0] != 8'h00) begin
        // pick up the fix flag from RMC status or GGA quality
        if (cur_kind == nsc_pkg::KIND_RMC && term_no == nsc_pkg::RMC_STATUS_TERM)
          cur_fix = (head_chars[0] == nsc_pkg::CHAR_FIX_OK);
        else if (cur_kind == nsc_pkg::KIND_GGA && term_no == nsc_pkg::GGA_QUALITY_TERM)
          cur_fix = (head_chars[0] > nsc_pkg::CHAR_ZERO);
      end
      if (term_no < nsc_pkg::INDEX_SAT) term_no++;
      term_chars  = 3'd0;
      in_sum_term = (c == nsc_pkg::CHAR_STAR);
    end else if (c == nsc_pkg::CHAR_DOLLAR || c == nsc_pkg::CHAR_HASH) begin
      // start a sentence, keep the counters
      crc_sentence = (c == nsc_pkg::CHAR_HASH);
      term_no      = 5'd0;
      term_chars   = 3'd0;
      sum_acc      = 8'h00;
      cur_kind     = nsc_pkg::KIND_OTHER;
      cur_sys      = nsc_pkg::SYS_UNKNOWN;
      in_sum_term  = 1'b0;
      cur_fix      = 1'b0;
    end else begin
      if (term_chars < nsc_pkg::HEAD_DEPTH) head_chars[term_chars] = c;
      if (term_chars < nsc_pkg::LEN_SAT) term_chars++;
      if (!in_sum_term) sum_acc ^= c;
    end
    r.kind   = cur_kind;
    r.fix    = cur_fix;
    r.sys    = cur_sys;
    r.passed = n_passed;
    r.failed = n_failed;
    r.fixes  = n_fixed;
    status_q.push_back(r);
  endtask

  // Offer one character, optionally after an idle burst, and hold it until taken
  task automatic send_char(input logic [7:0] c);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    parse_char(c);
  endtask

  // Drop valid and wait until every expected beat has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic start_frame(input logic [7:0] lead);
    frame_q.delete();
    frame_sum = 8'h00;
    frame_q.push_back(lead);
  endtask

  // Add a character that enters the running parity
  task automatic put_char(input logic [7:0] c);
    frame_q.push_back(c);
    frame_sum ^= c;
  endtask

  task automatic put_body(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return nsc_pkg::CHAR_ZERO + n;
    return (lower ? "a" : "A") + n - 8'd10;
  endfunction

  task automatic put_hex(input logic [7:0] v, input bit lower);
    frame_q.push_back(hex_digit(v[7:4], lower));
    frame_q.push_back(hex_digit(v[3:0], lower));
  endtask

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      0:       return "A";
      1:       return "V";
      2:       return 8'h00;
      3:       return ".";
      4, 5:    return nsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      6:       return "a" + 8'($urandom_range(0, 25));
      7:       return "A" + 8'($urandom_range(0, 25));
      8:       return "-";
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  task automatic put_term(input int len);
    repeat (len) put_char(field_char());
  endtask

  // Build one sentence into frame_q: mostly well formed, some broken or noise
  task automatic make_sentence();
    int pick;
    int n_terms;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      frame_q.delete();
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    start_frame(pick == 1 ? nsc_pkg::CHAR_HASH : nsc_pkg::CHAR_DOLLAR);
    if (pick == 2) frame_q.delete();
    // address term
    if ($urandom_range(0, 9) != 0) begin
      put_char("G");
      case ($urandom_range(0, 8))
        0: put_char("P");
        1: put_char("N");
        2: put_char("A");
        3: put_char("B");
        4: put_char("L");
        5: put_char("Q");
        6: put_char("I");
        7: put_char("G");
        default: put_char("X");
      endcase
      case ($urandom_range(0, 4))
        0: put_body("RMC");
        1: put_body("GGA");
        2: put_body("GSA");
        3: put_body("GSV");
        default: put_body("TXT");
      endcase
    end else begin
      put_term($urandom_range(0, 7));
    end
    // data terms, now and then enough to saturate the term index
    n_terms = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
    repeat (n_terms) begin
      put_char(nsc_pkg::CHAR_COMMA);
      put_term($urandom_range(0, 2) == 0 ? $urandom_range(3, 7) : $urandom_range(0, 2));
    end
    // checksum term
    pick = $urandom_range(0, 19);
    if (pick < 18) frame_q.push_back(nsc_pkg::CHAR_STAR);
    if (pick < 12) begin
      put_hex(frame_sum, 1'($urandom_range(0, 1)));
    end else if (pick < 14) begin
      put_hex(frame_sum ^ 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
    end else if (pick == 14) begin
      repeat ($urandom_range(0, 1)) frame_q.push_back(hex_digit(4'($urandom_range(0, 15)), 1'b0));
    end else if (pick == 15) begin
      put_hex(frame_sum, 1'b0);
      repeat ($urandom_range(1, 4)) frame_q.push_back(hex_digit(4'($urandom_range(0, 15)), 1'b0));
    end else if (pick == 16) begin
      repeat (2) frame_q.push_back(8'($urandom_range(8'h47, 8'hFF)));
    end else if (pick == 17) begin
      frame_q.push_back(nsc_pkg::CHAR_COMMA);
      put_hex(frame_sum, 1'b0);
    end
    case ($urandom_range(0, 4))
      0, 1, 2: begin
        frame_q.push_back(nsc_pkg::CHAR_CR);
        frame_q.push_back(nsc_pkg::CHAR_LF);
      end
      3:       frame_q.push_back(nsc_pkg::CHAR_LF);
      default: ;
    endcase
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_char(frame_q[i]);
  endtask

  // Extreme bytes before any start, then a checksum term with no digits
  task automatic test_stray_bytes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(nsc_pkg::CHAR_STAR);
    send_char(nsc_pkg::CHAR_LF);
  endtask

  // Valid RMC with status A: pass and one fix counted
  task automatic test_rmc_fix();
    start_frame(nsc_pkg::CHAR_DOLLAR);
    put_body("GPRMC,,A");
    frame_q.push_back(nsc_pkg::CHAR_STAR);
    put_hex(frame_sum, 1'b0);
    frame_q.push_back(nsc_pkg::CHAR_CR);
    send_frame();
  endtask

  // Wide CRC sentence closed by a comma gives no verdict; one-digit checksum fails
  task automatic test_wide_crc_and_short_sum();
    start_frame(nsc_pkg::CHAR_HASH);
    put_body("GAGSV");
    frame_q.push_back(nsc_pkg::CHAR_STAR);
    frame_q.push_back("Z");
    frame_q.push_back(nsc_pkg::CHAR_COMMA);
    send_frame();
    start_frame(nsc_pkg::CHAR_DOLLAR);
    put_body("GBGSA");
    frame_q.push_back(nsc_pkg::CHAR_STAR);
    frame_q.push_back("5");
    frame_q.push_back(nsc_pkg::CHAR_LF);
    send_frame();
  endtask

  task automatic test_random_stream(input int n_chars, input bit allow_idle);
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      idling = allow_idle && ($urandom_range(0, 3) != 0);
      make_sentence();
      send_frame();
      sent += frame_q.size();
    end
  endtask

  // Hold off the receiver while the sender keeps offering beats
  task automatic test_output_backpressure();
    idling = 1'b0;
    rx_hold_cycles = 150;
    start_frame(nsc_pkg::CHAR_DOLLAR);
    put_body("GNGSA,1,2,3,4");
    frame_q.push_back(nsc_pkg::CHAR_STAR);
    put_hex(frame_sum, 1'b0);
    frame_q.push_back(nsc_pkg::CHAR_CR);
    frame_q.push_back(nsc_pkg::CHAR_LF);
    send_frame();
  endtask

  // Pause the sender until the block has delivered everything
  task automatic test_input_pause();
    idling = 1'b1;
    make_sentence();
    send_frame();
    wait_drained();
    make_sentence();
    send_frame();
  endtask

  task automatic report_mismatch(input string why, input char_status_t want,
                                 input char_status_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s at beat %0d: expected ok=%b bad=%b kind=%0d fix=%b sys=%0d ",
               why, results_seen, want.ok, want.bad, want.kind, want.fix, want.sys,
               "pass=%0d fail=%0d fixes=%0d / got ok=%b bad=%b kind=%0d fix=%b sys=%0d ",
               want.passed, want.failed, want.fixes, got.ok, got.bad, got.kind, got.fix,
               got.sys, "pass=%0d fail=%0d fixes=%0d", got.passed, got.failed, got.fixes);
  endtask

  // Compare each result beat with the oldest expectation
  initial begin
    char_status_t got;
    char_status_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got = {out_sentence_ok, out_checksum_bad, out_sentence_kind, out_has_fix,
               out_system_code, out_passed_total, out_failed_total, out_fix_total};
        if (status_q.size() == 0) begin
          want = 'x;
          report_mismatch("unexpected beat", want, got);
        end else begin
          want = status_q.pop_front();
          if (got !== want) report_mismatch("mismatch", want, got);
        end
        results_seen++;
      end
    end
  end

  // Drive out_ready: long hold-off on request, random stall bursts while idling
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when no beat moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_char  <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_stray_bytes();
    test_rmc_fix();
    test_wide_crc_and_short_sum();
    test_random_stream(250, 1'b1);
    test_output_backpressure();
    test_input_pause();
    test_random_stream(120, 1'b0);
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && status_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
design/nsc_pkg.sv
design/nsc_term_eval.sv
design/nmea_sentence_checker.sv
tb/sv/tb_nmea_sentence_checker.sv
